>>> rtl/fbsc_pkg.sv
// ----------------------------------------------------------------------------
// fbsc_pkg: shared types and constants for the frustum cull unit
// Fixed-point widths, the result code, register indexes and stage enables.
// ----------------------------------------------------------------------------
`default_nettype none

package fbsc_pkg;

  // Number of plane registers that exist in the register file
  localparam int PLANE_REGS = 6;

  // Field widths
  localparam int COORD_W    = 16;                 // Q8.8 coordinates, Q1.14 normals
  localparam int PLANE_W    = 4 * COORD_W;        // a, b, c, d packed
  localparam int CFG_IDX_W  = 3;
  localparam int PROD_W     = 2 * COORD_W;        // Q1.14 * Q8.8 -> 22 fraction bits
  localparam int FRAC_SHIFT = 14;                 // aligns Q8.8 to 22 fraction bits
  localparam int DIST_W     = 35;                 // exact sum of three products plus d

  // Three coordinates, x lowest
  typedef logic [2:0][COORD_W-1:0] vec3_t;

  // Classification result
  typedef enum logic [1:0] {
    VIS_OUTSIDE   = 2'd0,
    VIS_INTERSECT = 2'd1,
    VIS_INSIDE    = 2'd2
  } vis_t;

  // Register file indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEFT   = 3'd0,
    REG_RIGHT  = 3'd1,
    REG_BOTTOM = 3'd2,
    REG_TOP    = 3'd3,
    REG_NEAR   = 3'd4,
    REG_FAR    = 3'd5
  } reg_idx_t;

  // Load enables for the stages that live inside each plane lane
  typedef struct packed {
    logic s1;   // products
    logic s2;   // distances
    logic s3;   // per-plane flags
  } stage_en_t;

endpackage

`default_nettype wire

>>> rtl/fbsc_plane_lane.sv
// ----------------------------------------------------------------------------
// fbsc_plane_lane: one frustum plane test
// Picks corners, multiplies, sums the signed distance and flags the plane.
// ----------------------------------------------------------------------------
`default_nettype none

module fbsc_plane_lane
  import fbsc_pkg::*;
(
  input  wire logic                        clk,
  input  wire stage_en_t                   en,
  input  wire logic [PLANE_W-1:0]          plane,
  // stage 0 word
  input  wire logic                        op_s0,
  input  wire vec3_t                       mn_s0,
  input  wire vec3_t                       mx_s0,
  input  wire vec3_t                       ctr_s0,
  // stage 2 side data
  input  wire logic                        op_s2,
  input  wire logic signed [DIST_W-1:0]    rad_s2,
  // stage 3 flags
  output logic                             out_hit,
  output logic                             part_hit
);

  vec3_t                     pos_c;
  vec3_t                     neg_c;
  logic signed [PROD_W-1:0]  pos_prod [3];
  logic signed [PROD_W-1:0]  neg_prod [3];
  logic signed [DIST_W-1:0]  d_term;
  logic signed [DIST_W-1:0]  pos_dist;
  logic signed [DIST_W-1:0]  neg_dist;

  // Corner pick: positive corner takes max where the normal is >= 0
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (op_s0) begin
        pos_c[k] = ctr_s0[k];
        neg_c[k] = ctr_s0[k];
      end else if (!plane[COORD_W*k + COORD_W-1]) begin
        pos_c[k] = mx_s0[k];
        neg_c[k] = mn_s0[k];
      end else begin
        pos_c[k] = mn_s0[k];
        neg_c[k] = mx_s0[k];
      end
    end
  end

  // Stage 1: products, one per axis and corner
  always_ff @(posedge clk) begin
    if (en.s1) begin
      for (int k = 0; k < 3; k++) begin
        pos_prod[k] <= $signed(plane[COORD_W*k +: COORD_W]) * $signed(pos_c[k]);
        neg_prod[k] <= $signed(plane[COORD_W*k +: COORD_W]) * $signed(neg_c[k]);
      end
    end
  end

  // Offset d scaled to 22 fraction bits
  assign d_term = $signed({{(DIST_W-COORD_W-FRAC_SHIFT){plane[PLANE_W-1]}},
                           plane[PLANE_W-1 -: COORD_W], {FRAC_SHIFT{1'b0}}});

  // Stage 2: signed distances
  always_ff @(posedge clk) begin
    if (en.s2) begin
      pos_dist <= DIST_W'(pos_prod[0]) + DIST_W'(pos_prod[1])
                + DIST_W'(pos_prod[2]) + d_term;
      neg_dist <= DIST_W'(neg_prod[0]) + DIST_W'(neg_prod[1])
                + DIST_W'(neg_prod[2]) + d_term;
    end
  end

  // Stage 3: plane flags (sphere uses the center distance in both)
  always_ff @(posedge clk) begin
    if (en.s3) begin
      if (op_s2) begin
        out_hit  <= pos_dist < -rad_s2;
        part_hit <= pos_dist < rad_s2;
      end else begin
        out_hit  <= pos_dist[DIST_W-1];
        part_hit <= neg_dist[DIST_W-1];
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/frustum_box_sphere_cull_unit.sv
// ----------------------------------------------------------------------------
// frustum_box_sphere_cull_unit: box / sphere against frustum planes
// Classifies a bounding volume as outside, intersecting or inside.
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid/in_ready, op, box_*, center_*,   | in
//          | sphere_radius                             |
//  out     | out_valid/out_ready, visibility           | out
//  cfg     | cfg_we, cfg_index, cfg_data               | in
//
//  Five register stages: input, products, distances, plane flags, result.
//  Words pass the stages in order; one per cycle while out_ready is high.
//  Each stage loads when empty or when the stage after it moves, so a stall
//  at out_ready backs up the pipe without loss; bubbles collapse.
//  Reset clears the valid bits and the plane registers to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module frustum_box_sphere_cull_unit
  import fbsc_pkg::*;
#(
  parameter int NUM_PLANES = 6
)
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // input channel
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  op,
  input  wire logic [COORD_W-1:0]    box_min_x,
  input  wire logic [COORD_W-1:0]    box_min_y,
  input  wire logic [COORD_W-1:0]    box_min_z,
  input  wire logic [COORD_W-1:0]    box_max_x,
  input  wire logic [COORD_W-1:0]    box_max_y,
  input  wire logic [COORD_W-1:0]    box_max_z,
  input  wire logic [COORD_W-1:0]    center_x,
  input  wire logic [COORD_W-1:0]    center_y,
  input  wire logic [COORD_W-1:0]    center_z,
  input  wire logic [COORD_W-1:0]    sphere_radius,
  // output channel
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [1:0]                 visibility,
  // configuration
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [PLANE_W-1:0]    cfg_data
);

  localparam int LANES = (NUM_PLANES < PLANE_REGS) ? NUM_PLANES : PLANE_REGS;

  logic [PLANE_W-1:0]         plane_reg [PLANE_REGS];

  logic                       v0, v1, v2, v3, v4;
  logic                       en0, en1, en2, en3, en4;
  stage_en_t                  lane_en;

  logic                       op_s0, op_s1, op_s2;
  vec3_t                      mn_s0, mx_s0, ctr_s0;
  logic [COORD_W-1:0]         rad_s0, rad_s1;
  logic signed [DIST_W-1:0]   rad_s2;

  logic [LANES-1:0]           out_hit;
  logic [LANES-1:0]           part_hit;
  vis_t                       vis_next;
  vis_t                       vis_q;

  // Register file writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PLANE_REGS; i++) begin
        plane_reg[i] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LEFT:   plane_reg[0] <= cfg_data;
        REG_RIGHT:  plane_reg[1] <= cfg_data;
        REG_BOTTOM: plane_reg[2] <= cfg_data;
        REG_TOP:    plane_reg[3] <= cfg_data;
        REG_NEAR:   plane_reg[4] <= cfg_data;
        REG_FAR:    plane_reg[5] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage load enables: a stage moves when empty or when its successor moves
  assign en4 = !v4 || out_ready;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign en0 = !v0 || en1;
  assign in_ready = en0;

  assign lane_en.s1 = en1;
  assign lane_en.s2 = en2;
  assign lane_en.s3 = en3;

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en0) v0 <= in_valid;
      if (en1) v1 <= v0;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  // Stage 0: input word
  always_ff @(posedge clk) begin
    if (en0) begin
      op_s0  <= op;
      mn_s0  <= {box_min_z, box_min_y, box_min_x};
      mx_s0  <= {box_max_z, box_max_y, box_max_x};
      ctr_s0 <= {center_z, center_y, center_x};
      rad_s0 <= sphere_radius;
    end
  end

  // Side data that travels with the lanes
  always_ff @(posedge clk) begin
    if (en1) begin
      op_s1  <= op_s0;
      rad_s1 <= rad_s0;
    end
    if (en2) begin
      op_s2  <= op_s1;
      rad_s2 <= $signed({{(DIST_W-COORD_W-FRAC_SHIFT){1'b0}}, rad_s1,
                         {FRAC_SHIFT{1'b0}}});
    end
  end

  // One lane per tested plane
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    fbsc_plane_lane u_lane (
      .clk      (clk),
      .en       (lane_en),
      .plane    (plane_reg[g]),
      .op_s0    (op_s0),
      .mn_s0    (mn_s0),
      .mx_s0    (mx_s0),
      .ctr_s0   (ctr_s0),
      .op_s2    (op_s2),
      .rad_s2   (rad_s2),
      .out_hit  (out_hit[g]),
      .part_hit (part_hit[g])
    );
  end

  // Combine plane flags: any outside wins, then any intersecting
  always_comb begin
    if (|out_hit) begin
      vis_next = VIS_OUTSIDE;
    end else if (|part_hit) begin
      vis_next = VIS_INTERSECT;
    end else begin
      vis_next = VIS_INSIDE;
    end
  end

  // Stage 4: result register
  always_ff @(posedge clk) begin
    if (en4) begin
      vis_q <= vis_next;
    end
  end

  assign out_valid  = v4;
  assign visibility = vis_q;

`ifndef SYNTHESIS
  // An empty result register means the whole pipe can take a word
  a_empty_out_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("in_ready low while result stage empty");

  // A plane flagged outside must yield an outside result
  a_outside_wins: assert property (@(posedge clk) disable iff (rst)
    (v3 && en4 && (|out_hit)) |=> (visibility == VIS_OUTSIDE))
    else $error("outside plane not reported as outside");

  // No plane flags at all must yield an inside result
  a_inside_clean: assert property (@(posedge clk) disable iff (rst)
    (v3 && en4 && !(|out_hit) && !(|part_hit)) |=> (visibility == VIS_INSIDE))
    else $error("clean volume not reported as inside");

  // Only the three defined codes leave the block
  a_vis_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (visibility == VIS_OUTSIDE || visibility == VIS_INTERSECT ||
                   visibility == VIS_INSIDE))
    else $error("undefined visibility code");
`endif

endmodule

`default_nettype wire
